FILE: hdl/udrm_pkg.sv
`default_nettype none

package udrm_pkg;

    // Item codes carried on s_opcode
    typedef enum logic [1:0] {
        OP_CLASS_WR  = 2'd0,
        OP_TRANS_WR  = 2'd1,
        OP_ACCEPT_WR = 2'd2,
        OP_MATCH     = 2'd3
    } opcode_t;

    // Lead byte boundaries of UTF-8 sequences
    localparam logic [7:0] LEAD_TRAIL1 = 8'hC0;
    localparam logic [7:0] LEAD_TRAIL2 = 8'hE0;
    localparam logic [7:0] LEAD_TRAIL3 = 8'hF0;
    localparam logic [7:0] LEAD_BAD    = 8'hF8;

    // One item as it travels down the lookup pipeline
    typedef struct packed {
        opcode_t     op;
        logic        chr;       // beat completes a character to be looked up
        logic        last;      // final byte of the string
        logic        dec_fail;  // decode has failed the string
        logic [16:0] idx;
        logic [9:0]  val;
    } tok_t;

    // Number of trailing bytes announced by a valid lead byte
    function automatic logic [1:0] lead_trail(input logic [7:0] b);
        logic [1:0] t;
        if (b < LEAD_TRAIL1) begin
            t = 2'd0;
        end else if (b < LEAD_TRAIL2) begin
            t = 2'd1;
        end else if (b < LEAD_TRAIL3) begin
            t = 2'd2;
        end else begin
            t = 2'd3;
        end
        return t;
    endfunction

    // Offset removed from the accumulated bits, modulo 2^16, per sequence length
    function automatic logic [15:0] seq_offset(input logic [1:0] len);
        logic [15:0] o;
        case (len)
            2'd0:    o = 16'h0000;
            2'd1:    o = 16'h3080;
            2'd2:    o = 16'h2080;  // 0x000E2080 kept to 16 bits
            2'd3:    o = 16'h2080;  // 0x03C82080 kept to 16 bits
            default: o = 16'h0000;
        endcase
        return o;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/utf8_dfa_regex_matcher_top.sv
// Channel  Dir  Handshake              Payload
// cfg      in   cfg_valid/cfg_ready    cfg_wdata (class of the dot wildcard)
// s_       in   s_valid/s_ready        s_opcode, s_table_index, s_entry_value,
//                                      s_text_byte, s_last_byte
// m_       out  m_valid/m_ready        m_matched (one beat per last match byte)
//
// Loads and bytes that do not finish a character are not held by the state hazard.
// A finished character waits in stage 2 while the one ahead is still resolving,
// and in stage 3 when its class is mapped but has no transition and the dot class
// is tried: the transition table has one read port and the next lookup waits for
// the state the previous one writes. m_valid rises once the last byte reaches
// stage 4, later by any such waits. After reset a clearing pass over
// max(CODE_POINTS, MAX_CLASSES*DFA_STATES) addresses (131072 by default) zeroes
// all stores; s_ready stays low until it ends. A stalled result holds in the
// output stage; later items keep moving until the next last byte reaches stage 3,
// and two more are taken behind it.
`default_nettype none

module utf8_dfa_regex_matcher_top
    import udrm_pkg::*;
#(
    parameter int DFA_STATES  = 512,
    parameter int MAX_CLASSES = 256,
    parameter int CODE_POINTS = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_wdata,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [16:0] s_table_index,
    input  wire logic [9:0]  s_entry_value,
    input  wire logic [7:0]  s_text_byte,
    input  wire logic        s_last_byte,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_matched
);

    localparam int SW        = $clog2(DFA_STATES + 1);
    localparam int CW        = $clog2(MAX_CLASSES + 1);
    localparam int TT_DEPTH  = MAX_CLASSES * DFA_STATES;
    localparam int TTAW      = $clog2(TT_DEPTH);
    localparam int CMAW      = $clog2(CODE_POINTS);
    localparam int ACCAW     = $clog2(DFA_STATES);
    localparam int CLR_DEPTH = (TT_DEPTH > CODE_POINTS) ? TT_DEPTH : CODE_POINTS;
    localparam int CLRW      = $clog2(CLR_DEPTH);

    // ---------------------------------------------------------------
    // Configuration and clearing pass
    // ---------------------------------------------------------------
    logic [8:0]      dot_class_reg;
    logic [TTAW-1:0] dot_base_reg;
    logic            dot_ok;
    logic            clr_busy_reg;
    logic [CLRW-1:0] clr_cnt_reg;

    assign cfg_ready = 1'b1;
    assign dot_ok    = (dot_class_reg != 9'd0) && (32'(dot_class_reg) <= MAX_CLASSES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_class_reg <= 9'd0;
        end else if (cfg_valid && cfg_ready) begin
            dot_class_reg <= cfg_wdata;
        end
    end

    // Precompute the row base of the dot class
    always_ff @(posedge aclk) begin
        dot_base_reg <= TTAW'((32'(dot_class_reg) - 32'd1) * 32'(DFA_STATES));
    end

    // Sweep every store once after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + CLRW'(1);
            if (clr_cnt_reg == CLRW'(CLR_DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control
    // ---------------------------------------------------------------
    logic            p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg;
    tok_t            p1_tok_reg, p2_tok_reg, p3_tok_reg;
    logic            p1_cmrd_reg;
    logic            p2_cls_ok_reg;
    logic [TTAW-1:0] p2_base_reg;
    logic            p3_rd_reg, p3_dot_reg;
    logic            p4_fail_reg;

    logic [CW-1:0]   cm_q;
    logic [SW-1:0]   tt_q;
    logic            acc_q;

    logic [SW-1:0]   dfa_state_reg;
    logic            dfa_fail_reg;

    logic            s_acc, is_match;
    logic            out_free, p3_res, p3_hit, p3_retry, p3_go, p3_free, hazard;
    logic            p2_go, p2_free, p1_go, p1_free;

    assign p3_res   = p3_v_reg && (p3_tok_reg.op == OP_MATCH) && p3_tok_reg.last;
    assign p3_hit   = p3_rd_reg && (tt_q != '0);
    assign p3_retry = p3_v_reg && p3_tok_reg.chr && !p3_hit && !p3_dot_reg && dot_ok;
    assign out_free = !p4_v_reg || m_ready;
    assign p3_go    = p3_v_reg && !p3_retry && (!p3_res || out_free);
    assign p3_free  = !p3_v_reg || p3_go;
    // hold a lookup until the state written by the item ahead has landed
    assign hazard   = p3_v_reg && (p3_tok_reg.chr || p3_res);
    assign p2_go    = p2_v_reg && p3_free && !(p2_tok_reg.chr && hazard);
    assign p2_free  = !p2_v_reg || p2_go;
    assign p1_go    = p1_v_reg && p2_free;
    assign p1_free  = !p1_v_reg || p1_go;
    assign s_ready  = !clr_busy_reg && p1_free;
    assign s_acc    = s_valid && s_ready;
    assign is_match = (opcode_t'(s_opcode) == OP_MATCH);

    // ---------------------------------------------------------------
    // UTF-8 decode at the input beat
    // ---------------------------------------------------------------
    logic [15:0] code_accum_reg;
    logic [1:0]  bytes_left_reg, seq_len_reg;
    logic        dec_fail_reg;

    logic [15:0] acc_n, cp;
    logic [1:0]  bl_n, sl_n, trail;
    logic        bad_lead, chr_n, cp_ok;
    tok_t        tok_in;

    always_comb begin
        acc_n    = code_accum_reg;
        bl_n     = bytes_left_reg;
        sl_n     = seq_len_reg;
        bad_lead = 1'b0;
        chr_n    = 1'b0;
        trail    = lead_trail(s_text_byte);
        if (!dec_fail_reg) begin
            if (bytes_left_reg == 2'd0) begin
                if (s_text_byte >= LEAD_BAD) begin
                    bad_lead = 1'b1;
                end else begin
                    acc_n = {8'h00, s_text_byte};
                    bl_n  = trail;
                    sl_n  = trail;
                    chr_n = (trail == 2'd0);
                end
            end else begin
                acc_n = {code_accum_reg[9:0], 6'b0} + {8'h00, s_text_byte};
                bl_n  = bytes_left_reg - 2'd1;
                chr_n = (bytes_left_reg == 2'd1);
            end
        end
        cp    = acc_n - seq_offset(sl_n);
        cp_ok = (32'(cp) < CODE_POINTS);

        tok_in.op       = opcode_t'(s_opcode);
        tok_in.chr      = is_match && chr_n;
        tok_in.last     = s_last_byte;
        tok_in.dec_fail = dec_fail_reg || bad_lead || (s_last_byte && (bl_n != 2'd0));
        tok_in.idx      = s_table_index;
        tok_in.val      = s_entry_value;
    end

    // Advance decode state; drop it at the end of each string
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_accum_reg <= 16'd0;
            bytes_left_reg <= 2'd0;
            seq_len_reg    <= 2'd0;
            dec_fail_reg   <= 1'b0;
        end else if (s_acc && is_match) begin
            if (s_last_byte) begin
                code_accum_reg <= 16'd0;
                bytes_left_reg <= 2'd0;
                seq_len_reg    <= 2'd0;
                dec_fail_reg   <= 1'b0;
            end else begin
                code_accum_reg <= acc_n;
                bytes_left_reg <= bl_n;
                seq_len_reg    <= sl_n;
                dec_fail_reg   <= dec_fail_reg || bad_lead;
            end
        end
    end

    // ---------------------------------------------------------------
    // Class map: read or written at the input beat
    // ---------------------------------------------------------------
    logic            cm_we, cm_re;
    logic [CMAW-1:0] cm_waddr;
    logic [CW-1:0]   cm_wdata;

    assign cm_re = s_acc && tok_in.chr && cp_ok;

    always_comb begin
        if (clr_busy_reg) begin
            cm_we    = (32'(clr_cnt_reg) < CODE_POINTS);
            cm_waddr = clr_cnt_reg[CMAW-1:0];
            cm_wdata = '0;
        end else begin
            cm_we    = s_acc && (opcode_t'(s_opcode) == OP_CLASS_WR)
                       && (32'(s_table_index) < CODE_POINTS)
                       && (32'(s_entry_value) <= MAX_CLASSES);
            cm_waddr = s_table_index[CMAW-1:0];
            cm_wdata = CW'(s_entry_value);
        end
    end

    udrm_ram #(
        .WIDTH (CW),
        .DEPTH (CODE_POINTS)
    ) u_class_map (
        .clk   (aclk),
        .we    (cm_we),
        .waddr (cm_waddr),
        .wdata (cm_wdata),
        .re    (cm_re),
        .raddr (cp[CMAW-1:0]),
        .rdata (cm_q)
    );

    // ---------------------------------------------------------------
    // Stage 1: class read back, row base worked out
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
        end else if (p1_free) begin
            p1_v_reg <= s_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            p1_tok_reg  <= tok_in;
            p1_cmrd_reg <= cm_re;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: transition read or write
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_v_reg <= 1'b0;
        end else if (p2_free) begin
            p2_v_reg <= p1_go;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_go) begin
            p2_tok_reg    <= p1_tok_reg;
            p2_cls_ok_reg <= p1_cmrd_reg && (cm_q != '0);
            p2_base_reg   <= TTAW'((32'(cm_q) - 32'd1) * 32'(DFA_STATES));
        end
    end

    logic [SW-1:0]   st_m1;
    logic [TTAW-1:0] prim_addr, dot_addr, tt_raddr, tt_waddr;
    logic [SW-1:0]   tt_wdata;
    logic            tt_re, tt_we, p2_rd;

    assign st_m1     = dfa_state_reg - SW'(1);
    assign prim_addr = p2_base_reg + TTAW'(st_m1);
    assign dot_addr  = dot_base_reg + TTAW'(st_m1);
    assign p2_rd     = p2_tok_reg.chr && (p2_cls_ok_reg || dot_ok);
    assign tt_re     = (p2_go && p2_rd) || p3_retry;
    assign tt_raddr  = (p3_retry || !p2_cls_ok_reg) ? dot_addr : prim_addr;

    always_comb begin
        if (clr_busy_reg) begin
            tt_we    = (32'(clr_cnt_reg) < TT_DEPTH);
            tt_waddr = TTAW'(clr_cnt_reg);
            tt_wdata = '0;
        end else begin
            tt_we    = p2_go && (p2_tok_reg.op == OP_TRANS_WR)
                       && (32'(p2_tok_reg.idx) < TT_DEPTH)
                       && (32'(p2_tok_reg.val) <= DFA_STATES);
            tt_waddr = TTAW'(p2_tok_reg.idx);
            tt_wdata = SW'(p2_tok_reg.val);
        end
    end

    udrm_ram #(
        .WIDTH (SW),
        .DEPTH (TT_DEPTH)
    ) u_trans (
        .clk   (aclk),
        .we    (tt_we),
        .waddr (tt_waddr),
        .wdata (tt_wdata),
        .re    (tt_re),
        .raddr (tt_raddr),
        .rdata (tt_q)
    );

    // ---------------------------------------------------------------
    // Stage 3: resolve the step, retry with the dot class on a miss
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_v_reg <= 1'b0;
        end else if (p3_free) begin
            p3_v_reg <= p2_go;
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_go) begin
            p3_tok_reg <= p2_tok_reg;
            p3_rd_reg  <= p2_rd;
            p3_dot_reg <= !p2_cls_ok_reg;
        end else if (p3_retry) begin
            p3_rd_reg  <= 1'b1;
            p3_dot_reg <= 1'b1;
        end
    end

    logic [SW-1:0] final_st, fin_m1;
    logic          p3_fail;

    assign final_st = (p3_tok_reg.chr && p3_hit) ? tt_q : dfa_state_reg;
    assign fin_m1   = final_st - SW'(1);
    assign p3_fail  = p3_tok_reg.dec_fail || dfa_fail_reg || (p3_tok_reg.chr && !p3_hit);

    // Update the DFA state; return it to the start state after each string
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dfa_state_reg <= SW'(1);
            dfa_fail_reg  <= 1'b0;
        end else if (p3_go) begin
            if (p3_res) begin
                dfa_state_reg <= SW'(1);
                dfa_fail_reg  <= 1'b0;
            end else if (p3_tok_reg.chr) begin
                if (p3_hit) begin
                    dfa_state_reg <= tt_q;
                end else begin
                    dfa_fail_reg <= 1'b1;
                end
            end
        end
    end

    logic             acc_we, acc_re;
    logic [ACCAW-1:0] acc_waddr;
    logic             acc_wdata;

    assign acc_re = p3_go && p3_res;

    always_comb begin
        if (clr_busy_reg) begin
            acc_we    = (32'(clr_cnt_reg) < DFA_STATES);
            acc_waddr = clr_cnt_reg[ACCAW-1:0];
            acc_wdata = 1'b0;
        end else begin
            acc_we    = p3_go && (p3_tok_reg.op == OP_ACCEPT_WR)
                        && (32'(p3_tok_reg.idx) < DFA_STATES);
            acc_waddr = p3_tok_reg.idx[ACCAW-1:0];
            acc_wdata = (p3_tok_reg.val != 10'd0);
        end
    end

    udrm_ram #(
        .WIDTH (1),
        .DEPTH (DFA_STATES)
    ) u_accept (
        .clk   (aclk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .re    (acc_re),
        .raddr (fin_m1[ACCAW-1:0]),
        .rdata (acc_q)
    );

    // ---------------------------------------------------------------
    // Stage 4: result beat, held until taken
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_v_reg <= 1'b0;
        end else if (p3_go && p3_res) begin
            p4_v_reg <= 1'b1;
        end else if (m_ready) begin
            p4_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p3_go && p3_res) begin
            p4_fail_reg <= p3_fail;
        end
    end

    assign m_valid   = p4_v_reg;
    assign m_matched = !p4_fail_reg && acc_q;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_retry_once: assert property (@(posedge aclk) disable iff (!aresetn)
        p3_retry |=> !p3_retry)
        else $error("dot fallback retried twice for one character");

    a_state_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (dfa_state_reg != '0) && (32'(dfa_state_reg) <= DFA_STATES))
        else $error("DFA state outside 1..DFA_STATES");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(acc_q))
        else $error("accept flag read again under a stalled result");

    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !(p1_v_reg || p2_v_reg || p3_v_reg || p4_v_reg))
        else $error("item in flight during clearing pass");

endmodule

`default_nettype wire

FILE: hdl/udrm_ram.sv
`default_nettype none

module udrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port, and registered read that holds while re is low
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: tb/sv/utf8_dfa_regex_matcher_top_tb.sv
`timescale 1ns / 1ps

module utf8_dfa_regex_matcher_top_tb;

    import udrm_pkg::*;

    localparam int N_STATES  = 512;
    localparam int N_CLASSES = 256;
    localparam int N_CODES   = 65536;

    // Offsets removed from the wrapped accumulator, per sequence length
    localparam logic [15:0] OFS_TWO   = 16'h3080;
    localparam logic [15:0] OFS_THREE = 16'h2080;
    localparam logic [15:0] OFS_FOUR  = 16'h2080;

    typedef struct {
        opcode_t     op;
        logic [16:0] tbl_idx;
        logic [9:0]  ent_val;
        logic [7:0]  byte_val;
        logic        is_last;
    } match_item_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_wdata     = '0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode      = '0;
    logic [16:0] s_table_index = '0;
    logic [9:0]  s_entry_value = '0;
    logic [7:0]  s_text_byte   = '0;
    logic        s_last_byte   = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic        m_matched;

    // Shadow copy of the matcher: stores, register and per-string decode state
    bit   [8:0]  class_of   [N_CODES];
    bit   [9:0]  next_state [N_CLASSES * N_STATES];
    bit          accepting  [N_STATES];
    logic [8:0]  dot_class  = '0;
    logic [9:0]  cur_state  = 10'd1;
    logic [15:0] code_acc   = '0;
    int          trail_left = 0;
    int          seq_len    = 0;
    bit          str_dead   = 1'b0;

    match_item_t pending_items[$];
    bit          expected_matched[$];
    match_item_t cur_item;

    int items_queued    = 0;
    int strings_queued  = 0;
    int items_taken     = 0;
    int results_checked = 0;
    int dot_writes      = 0;
    int fail_count      = 0;
    int idle_left       = 0;
    int stall_left      = 0;
    int calm_s          = 0;
    int calm_m          = 0;

    // Dictionary the random DFA is built on
    int unsigned cp_pool[16] = '{'h0000, 'h0041, 'h0042, 'h0061, 'h007F, 'h0080, 'h00BF,
                                 'h00E9, 'h03A9, 'h07FF, 'h0800, 'h1234, 'h4E2D, 'hD7FF,
                                 'hFFFE, 'hFFFF};
    int unsigned cls_set[6]   = '{1, 2, 3, 4, 5, 256};
    int unsigned state_set[6] = '{1, 2, 3, 4, 5, 512};

    utf8_dfa_regex_matcher_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_table_index (s_table_index),
        .s_entry_value (s_entry_value),
        .s_text_byte   (s_text_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_matched     (m_matched)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Next state for a class from a state; zero when either is out of range
    function automatic logic [9:0] lookup_next(input logic [8:0] cls, input logic [9:0] st);
        if (cls == 0 || int'(cls) > N_CLASSES || st == 0 || int'(st) > N_STATES) begin
            return '0;
        end
        return next_state[(int'(cls) - 1) * N_STATES + int'(st) - 1];
    endfunction

    // Apply one accepted beat to the shadow matcher and record any result
    task automatic advance_dfa_model(input match_item_t it);
        logic [15:0] cp;
        logic [15:0] ofs;
        logic [9:0]  nx;
        bit          char_done;
        case (it.op)
            OP_CLASS_WR: begin
                if (int'(it.tbl_idx) < N_CODES && int'(it.ent_val) <= N_CLASSES) begin
                    class_of[it.tbl_idx[15:0]] = it.ent_val[8:0];
                end
            end
            OP_TRANS_WR: begin
                if (int'(it.tbl_idx) < N_CLASSES * N_STATES && int'(it.ent_val) <= N_STATES) begin
                    next_state[it.tbl_idx] = it.ent_val;
                end
            end
            OP_ACCEPT_WR: begin
                if (int'(it.tbl_idx) < N_STATES) begin
                    accepting[it.tbl_idx] = (it.ent_val != 0);
                end
            end
            default: begin
                char_done = 1'b0;
                if (!str_dead) begin
                    if (trail_left == 0) begin
                        if (it.byte_val >= LEAD_BAD) begin
                            str_dead = 1'b1;
                        end else begin
                            if (it.byte_val < LEAD_TRAIL1) begin
                                trail_left = 0;
                            end else if (it.byte_val < LEAD_TRAIL2) begin
                                trail_left = 1;
                            end else if (it.byte_val < LEAD_TRAIL3) begin
                                trail_left = 2;
                            end else begin
                                trail_left = 3;
                            end
                            code_acc  = {8'h00, it.byte_val};
                            seq_len   = trail_left;
                            char_done = (trail_left == 0);
                        end
                    end else begin
                        code_acc   = (code_acc << 6) + {8'h00, it.byte_val};
                        trail_left = trail_left - 1;
                        char_done  = (trail_left == 0);
                    end
                end
                // Step on the class, retry with the dot class from the same state
                if (char_done) begin
                    case (seq_len)
                        1:       ofs = OFS_TWO;
                        2:       ofs = OFS_THREE;
                        3:       ofs = OFS_FOUR;
                        default: ofs = '0;
                    endcase
                    cp = code_acc - ofs;
                    nx = lookup_next(class_of[cp], cur_state);
                    if (nx == 0) begin
                        nx = lookup_next(dot_class, cur_state);
                    end
                    if (nx == 0) begin
                        str_dead = 1'b1;
                    end else begin
                        cur_state = nx;
                    end
                end
                if (it.is_last) begin
                    expected_matched.push_back(!str_dead && trail_left == 0 &&
                                               accepting[cur_state - 1]);
                    cur_state  = 10'd1;
                    code_acc   = '0;
                    trail_left = 0;
                    seq_len    = 0;
                    str_dead   = 1'b0;
                end
            end
        endcase
    endtask

    // Gap length: mostly none, often short, now and then long, with calm stretches
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic queue_load(input opcode_t op, input int unsigned idx, input int unsigned val);
        match_item_t it;
        it.op       = op;
        it.tbl_idx  = 17'(idx);
        it.ent_val  = 10'(val);
        it.byte_val = 8'($urandom);
        it.is_last  = 1'($urandom);
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic queue_byte(input logic [7:0] b, input bit last);
        match_item_t it;
        it.op       = OP_MATCH;
        it.tbl_idx  = 17'($urandom);
        it.ent_val  = 10'($urandom);
        it.byte_val = b;
        it.is_last  = last;
        pending_items.push_back(it);
        items_queued++;
        if (last) strings_queued++;
    endtask

    // Random load: mostly onto the DFA dictionary, the rest anywhere in the index and value fields
    task automatic queue_random_load();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            queue_load(OP_CLASS_WR, cp_pool[$urandom_range(0, 15)],
                       ($urandom_range(0, 9) == 0) ? 0 : cls_set[$urandom_range(0, 5)]);
        end else if (r < 55) begin
            queue_load(OP_TRANS_WR, (cls_set[$urandom_range(0, 5)] - 1) * N_STATES +
                       state_set[$urandom_range(0, 5)] - 1,
                       ($urandom_range(0, 6) == 0) ? 0 : state_set[$urandom_range(0, 5)]);
        end else if (r < 70) begin
            queue_load(OP_ACCEPT_WR, state_set[$urandom_range(0, 5)] - 1,
                       $urandom_range(0, 1) ? $urandom_range(0, 1023) : 0);
        end else begin
            queue_load(opcode_t'($urandom_range(0, 2)), $urandom_range(0, 'h1FFFF),
                       $urandom_range(0, 1023));
        end
    endtask

    task automatic queue_string(input logic [7:0] str[$]);
        foreach (str[i]) begin
            // drop a load between bytes now and then
            if (i > 0 && $urandom_range(0, 99) < 3) queue_random_load();
            queue_byte(str[i], i == str.size() - 1);
        end
    endtask

    // Standard UTF-8 encoding, up to 21 bits
    task automatic push_utf8(input int unsigned cp, inout logic [7:0] q[$]);
        if (cp < 'h80) begin
            q.push_back(8'(cp));
        end else if (cp < 'h800) begin
            q.push_back(8'('hC0 | (cp >> 6)));
            q.push_back(8'('h80 | (cp & 'h3F)));
        end else if (cp < 'h10000) begin
            q.push_back(8'('hE0 | (cp >> 12)));
            q.push_back(8'('h80 | ((cp >> 6) & 'h3F)));
            q.push_back(8'('h80 | (cp & 'h3F)));
        end else begin
            q.push_back(8'('hF0 | (cp >> 18)));
            q.push_back(8'('h80 | ((cp >> 12) & 'h3F)));
            q.push_back(8'('h80 | ((cp >> 6) & 'h3F)));
            q.push_back(8'('h80 | (cp & 'h3F)));
        end
    endtask

    // Corner loads and strings on the reset value of the dot class
    task automatic queue_directed();
        queue_load(OP_CLASS_WR, 'h0041, 1);
        queue_load(OP_CLASS_WR, 'hFFFF, 256);
        queue_load(OP_CLASS_WR, 'h10000, 2);     // code point beyond the map
        queue_load(OP_CLASS_WR, 'h0042, 257);    // class beyond range
        queue_load(OP_TRANS_WR, 0, 2);
        queue_load(OP_TRANS_WR, 'h1FFFF, 512);
        queue_load(OP_TRANS_WR, 255 * N_STATES + 1, 512);
        queue_load(OP_TRANS_WR, 5, 513);         // next state beyond range
        queue_load(OP_ACCEPT_WR, 511, 1);
        queue_load(OP_ACCEPT_WR, 1, 1023);
        queue_load(OP_ACCEPT_WR, 512, 1);        // state beyond range
        queue_byte(8'h41, 1'b1);
        // three-byte character of the top code point
        queue_byte(8'h41, 1'b0);
        queue_byte(8'hEF, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hBF, 1'b1);
        // truncated sequence, then a stray continuation with no dot class
        queue_byte(8'hE0, 1'b1);
        queue_byte(8'h80, 1'b1);
        // four-byte character wrapping onto the top code point
        queue_byte(8'h41, 1'b0);
        queue_byte(8'hF4, 1'b0);
        queue_byte(8'h8F, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hBF, 1'b1);
        // bad lead byte kills the string, later bytes are dropped
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h41, 1'b1);
    endtask

    // Random phase: DFA loads, then strings mostly built from the dictionary
    task automatic run_phase(input bit full_fill);
        int          target;
        int          r;
        int unsigned cp;
        logic [7:0]  str[$];
        target = items_queued + 115;
        if (full_fill) begin
            foreach (cls_set[c]) begin
                foreach (state_set[s]) begin
                    queue_load(OP_TRANS_WR, (cls_set[c] - 1) * N_STATES + state_set[s] - 1,
                               ($urandom_range(0, 4) == 0) ? 0 : state_set[$urandom_range(0, 5)]);
                end
            end
            foreach (cp_pool[p]) begin
                queue_load(OP_CLASS_WR, cp_pool[p],
                           ($urandom_range(0, 9) == 0) ? 0 : cls_set[$urandom_range(0, 5)]);
            end
            foreach (state_set[s]) begin
                queue_load(OP_ACCEPT_WR, state_set[s] - 1, $urandom_range(0, 1));
            end
        end else begin
            repeat (20) queue_random_load();
        end
        while (items_queued < target) begin
            str.delete();
            repeat ($urandom_range(1, 5)) begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    cp = cp_pool[$urandom_range(0, 15)];
                    if (cp >= 'h80 && cp < 'hC0 && $urandom_range(0, 2) == 0) begin
                        str.push_back(8'(cp));                       // bare continuation
                    end else begin
                        if ($urandom_range(0, 5) == 0) cp += $urandom_range(1, 31) << 16;
                        push_utf8(cp, str);
                    end
                end else if (r < 85) begin
                    push_utf8($urandom_range(0, 1) ? $urandom_range(0, 'hFFFF)
                                                   : $urandom_range(0, 'h1FFFFF), str);
                end else begin
                    str.push_back(8'($urandom_range(0, 255)));
                end
            end
            // leave a sequence open at the end of the string
            if ($urandom_range(0, 99) < 6) str.push_back(8'($urandom_range('hC0, 'hF7)));
            queue_string(str);
        end
    endtask

    // Hold until everything is taken and answered, then let the pipeline drain
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_matched.size() != 0);
        repeat (16) @(negedge aclk);
    endtask

    task automatic write_dot(input logic [8:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= v;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        dot_class = v;
        dot_writes++;
        @(negedge aclk);
    endtask

    // Input driver: hold each beat until taken, random gaps between beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_dfa_model(cur_item);
                items_taken++;
            end
            if (!s_valid || s_ready) begin
                if (idle_left > 0) begin
                    idle_left--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    cur_item = pending_items.pop_front();
                    s_valid       <= 1'b1;
                    s_opcode      <= cur_item.op;
                    s_table_index <= cur_item.tbl_idx;
                    s_entry_value <= cur_item.ent_val;
                    s_text_byte   <= cur_item.byte_val;
                    s_last_byte   <= cur_item.is_last;
                    idle_left = pick_gap(calm_s);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random back-pressure, compare each beat with the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_matched.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: result beat with nothing outstanding, matched=%b",
                                 $realtime, m_matched);
                    end
                end else begin
                    bit want;
                    want = expected_matched.pop_front();
                    results_checked++;
                    if (m_matched !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: matched mismatch on result %0d: expected %b, got %b",
                                     $realtime, results_checked, want, m_matched);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                stall_left = ($urandom_range(0, 3) == 0) ? pick_gap(calm_m) : 0;
                m_ready <= 1'b1;
            end
        end
    end

    // Run limit, well past the clearing pass and the slowest stimulus
    initial begin
        #8000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        queue_directed();
        wait_idle();
        write_dot(9'd256);
        run_phase(1'b1);
        wait_idle();
        write_dot(9'(cls_set[$urandom_range(0, 4)]));
        run_phase(1'b0);
        wait_idle();
        write_dot(9'd0);
        run_phase(1'b0);
        wait_idle();
        write_dot(9'd1);
        run_phase(1'b0);
        wait_idle();
        $display("Covered %0d input beats, %0d strings, %0d dot-class writes",
                 items_taken, strings_queued, dot_writes);
        $display("Checked %0d match results, %0d discrepancies, %0d still outstanding",
                 results_checked, fail_count, expected_matched.size());
        if (fail_count == 0 && expected_matched.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
